// File: rtl/gone_pkg.sv
package gone_pkg;

	localparam int COORD_W   = 6;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int Q_DEPTH   = 2;
	localparam int NB_NUM    = 8;

	localparam logic [CFG_W-1:0] SIZE_RST = 7'd64;

	// request codes
	localparam logic [2:0] MODE_MARK  = 3'd0;
	localparam logic [2:0] MODE_CLEAR = 3'd1;
	localparam logic [2:0] MODE_FILL  = 3'd2;
	localparam logic [2:0] MODE_QUERY = 3'd3;
	localparam logic [2:0] MODE_LIST  = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIAG   = 2'd2;

	// neighbour offsets: W, E, N, S, NW, SE, NE, SW
	localparam logic signed [1:0] NB_DX [NB_NUM] =
		'{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, 2'sd1, 2'sd1, -2'sd1};
	localparam logic signed [1:0] NB_DY [NB_NUM] =
		'{2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};

	typedef struct packed {
		logic [2:0]         mode;
		logic [COORD_W-1:0] x_coord;
		logic [COORD_W-1:0] y_coord;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
	} cmd_t;

	typedef struct packed {
		logic               status;
		logic               blocked;
		logic               found;
		logic [COORD_W-1:0] neighbor_x;
		logic [COORD_W-1:0] neighbor_y;
		logic               last;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] grid_width;
		logic [CFG_W-1:0] grid_height;
		logic             diagonal_moves;
	} cfg_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ERR,
		OP_SET,
		OP_CLR,
		OP_QRY,
		OP_NBR
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x_end;
		logic [COORD_W-1:0] y_end;
	} job_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_EDIT,
		BK_QRY,
		BK_NB_MID,
		BK_NB_DN,
		BK_NB_EVAL,
		BK_EMIT
	} bk_state_t;

endpackage

// File: rtl/gone_ram.sv
module gone_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/gone_front.sv
module gone_front import gone_pkg::*; #(
	parameter int GRID_DIM = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output job_t head,
	output logic head_vld,
	input  logic pop
);

	localparam int QW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);
	localparam logic [COORD_W:0] DIM_EXT = (COORD_W + 1)'(GRID_DIM);

	job_t           job_new;
	job_t           q_mem_q [Q_DEPTH];
	logic [QW-1:0]  wr_ptr_q;
	logic [QW-1:0]  rd_ptr_q;
	logic [CW-1:0]  cnt_q;
	logic           push;
	logic           in_x;
	logic           in_y;
	logic           ye_over;

	// classify: fold storage bounds and corner order into the job code
	always_comb begin
		in_x    = {1'b0, cmd.x_coord} < DIM_EXT;
		in_y    = {1'b0, cmd.y_coord} < DIM_EXT;
		ye_over = {1'b0, cmd.y_end} >= DIM_EXT;
		job_new.op    = OP_NOP;
		job_new.x     = cmd.x_coord;
		job_new.y     = cmd.y_coord;
		job_new.x_end = cmd.x_coord;
		job_new.y_end = cmd.y_coord;
		case (cmd.mode)
			MODE_MARK: begin
				job_new.op = (in_x && in_y) ? OP_SET : OP_NOP;
			end
			MODE_CLEAR: begin
				job_new.op = (in_x && in_y) ? OP_CLR : OP_NOP;
			end
			MODE_FILL: begin
				job_new.x_end = cmd.x_end;
				job_new.y_end = ye_over ? COORD_W'(GRID_DIM - 1) : cmd.y_end;
				if (cmd.x_coord > cmd.x_end || cmd.y_coord > cmd.y_end) begin
					job_new.op = OP_ERR;
				end else if (!in_y) begin
					job_new.op = OP_NOP;
				end else begin
					job_new.op = OP_SET;
				end
			end
			MODE_QUERY: begin
				job_new.op = (in_x && in_y) ? OP_QRY : OP_NOP;
			end
			MODE_LIST: begin
				job_new.op = OP_NBR;
			end
			default: begin
				job_new.op = OP_NOP;
			end
		endcase
	end

	assign busy     = (cnt_q == CW'(Q_DEPTH));
	assign push     = start && !busy;
	assign head_vld = (cnt_q != '0);
	assign head     = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= QW'(wr_ptr_q + 1'b1);
			end
			if (pop) begin
				rd_ptr_q <= QW'(rd_ptr_q + 1'b1);
			end
			cnt_q <= CW'(cnt_q + CW'(push) - CW'(pop));
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= job_new;
		end
	end

endmodule

// File: rtl/gone_back.sv
module gone_back import gone_pkg::*; #(
	parameter int GRID_DIM = 64
) (
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  job_t head,
	input  logic head_vld,
	output logic pop,
	output rsp_t rsp,
	output logic rsp_valid
);

	localparam int AW = $clog2(GRID_DIM);
	localparam logic [COORD_W:0] DIM_EXT = (COORD_W + 1)'(GRID_DIM);

	bk_state_t           st_q, st_d;
	job_t                job_q, job_d;
	logic [AW-1:0]       row_q, row_d;
	logic [GRID_DIM-1:0] mask_q, mask_d, mask_new;
	logic [GRID_DIM-1:0] row_data, wdata, ram_rdata;
	logic [GRID_DIM-1:0] row_vld_q;
	logic [2:0]          up_q, up_d, mid_q, mid_d, dn_bits;
	logic [NB_NUM-1:0]   cand_q, cand_d, cand_now, sel;
	logic                hit;
	logic [AW-1:0]       rd_addr, rd_addr_q;
	logic                rd_ok, rd_ok_q;
	logic                we;
	logic                emit;
	rsp_t                rsp_d, rsp_q;
	logic                rsp_valid_q;
	logic [COORD_W:0]    wc, hc, x7, y7, xm1, xp1, ym1, yp1, hym1;
	logic                in_xl, in_xc, in_xr, in_yu, in_ym, in_yd;
	logic [COORD_W-1:0]  nx, ny;

	// obstruction bits at columns x-1, x, x+1 of one row; off-map columns read clear
	function automatic logic [2:0] col3(input logic [GRID_DIM-1:0] row,
			input logic [COORD_W-1:0] cx);
		logic [COORD_W:0] cl, cc, cr;
		logic [2:0]       b;
		cc = {1'b0, cx};
		cl = cc - 1'b1;
		cr = cc + 1'b1;
		b  = '0;
		if (cx != '0 && cl < DIM_EXT) begin
			b[0] = row[cl[AW-1:0]];
		end
		if (cc < DIM_EXT) begin
			b[1] = row[cc[AW-1:0]];
		end
		if (cr < DIM_EXT) begin
			b[2] = row[cr[AW-1:0]];
		end
		return b;
	endfunction

	gone_ram #(
		.WIDTH(GRID_DIM),
		.DEPTH(GRID_DIM)
	) u_rows (
		.clk   (clk),
		.we    (we),
		.waddr (row_q),
		.wdata (wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	// a row never written reads as clear
	assign row_data = (rd_ok_q && row_vld_q[rd_addr_q]) ? ram_rdata : '0;

	always_comb begin
		for (int i = 0; i < GRID_DIM; i++) begin
			mask_new[i] = ((COORD_W + 1)'(i) >= {1'b0, head.x}) &&
				((COORD_W + 1)'(i) <= {1'b0, head.x_end});
		end
	end

	// neighbour candidates from the three captured rows
	always_comb begin
		wc    = (cfg.grid_width > DIM_EXT) ? DIM_EXT : cfg.grid_width;
		hc    = (cfg.grid_height > DIM_EXT) ? DIM_EXT : cfg.grid_height;
		x7    = {1'b0, job_q.x};
		y7    = {1'b0, job_q.y};
		xm1   = x7 - 1'b1;
		xp1   = x7 + 1'b1;
		ym1   = y7 - 1'b1;
		yp1   = y7 + 1'b1;
		in_xl = (job_q.x != '0) && (xm1 < wc);
		in_xc = x7 < wc;
		in_xr = xp1 < wc;
		in_yu = (job_q.y != '0) && (ym1 < hc);
		in_ym = y7 < hc;
		in_yd = yp1 < hc;
		dn_bits = col3(row_data, job_q.x);
		cand_now[0] = in_xl && in_ym && !mid_q[0];
		cand_now[1] = in_xr && in_ym && !mid_q[2];
		cand_now[2] = in_xc && in_yu && !up_q[1];
		cand_now[3] = in_xc && in_yd && !dn_bits[1];
		cand_now[4] = cfg.diagonal_moves && in_xl && in_yu &&
			!up_q[0] && !up_q[1] && !mid_q[0];
		cand_now[5] = cfg.diagonal_moves && in_xr && in_yd &&
			!dn_bits[2] && !dn_bits[1] && !mid_q[2];
		cand_now[6] = cfg.diagonal_moves && in_xr && in_yu &&
			!up_q[2] && !up_q[1] && !mid_q[2];
		cand_now[7] = cfg.diagonal_moves && in_xl && in_yd &&
			!dn_bits[0] && !dn_bits[1] && !mid_q[0];
	end

	// lowest pending neighbour goes out first
	always_comb begin
		sel = '0;
		hit = 1'b0;
		nx  = '0;
		ny  = '0;
		for (int i = 0; i < NB_NUM; i++) begin
			if (cand_q[i] && !hit) begin
				sel[i] = 1'b1;
				hit    = 1'b1;
			end
		end
		for (int i = 0; i < NB_NUM; i++) begin
			if (sel[i]) begin
				nx = nx | COORD_W'(job_q.x + {{(COORD_W - 2){NB_DX[i][1]}}, NB_DX[i]});
				ny = ny | COORD_W'(job_q.y + {{(COORD_W - 2){NB_DY[i][1]}}, NB_DY[i]});
			end
		end
	end

	always_comb begin
		hym1    = {1'b0, head.y} - 1'b1;
		st_d    = st_q;
		job_d   = job_q;
		row_d   = row_q;
		mask_d  = mask_q;
		up_d    = up_q;
		mid_d   = mid_q;
		cand_d  = cand_q;
		pop     = 1'b0;
		rd_addr = rd_addr_q;
		rd_ok   = 1'b0;
		we      = 1'b0;
		wdata   = (job_q.op == OP_SET) ? (row_data | mask_q) : (row_data & ~mask_q);
		emit    = 1'b0;
		rsp_d   = '0;
		unique case (st_q)
			BK_IDLE: begin
				if (head_vld) begin
					pop    = 1'b1;
					job_d  = head;
					mask_d = mask_new;
					row_d  = head.y[AW-1:0];
					case (head.op)
						OP_SET, OP_CLR: begin
							rd_addr = head.y[AW-1:0];
							rd_ok   = 1'b1;
							st_d    = BK_EDIT;
						end
						OP_QRY: begin
							rd_addr = head.y[AW-1:0];
							rd_ok   = 1'b1;
							st_d    = BK_QRY;
						end
						OP_NBR: begin
							rd_addr = hym1[AW-1:0];
							rd_ok   = (head.y != '0) && (hym1 < DIM_EXT);
							st_d    = BK_NB_MID;
						end
						OP_ERR: begin
							emit         = 1'b1;
							rsp_d.status = 1'b1;
							rsp_d.last   = 1'b1;
						end
						default: begin
							emit       = 1'b1;
							rsp_d.last = 1'b1;
						end
					endcase
				end
			end
			BK_EDIT: begin
				we = 1'b1;
				if (row_q == job_q.y_end[AW-1:0]) begin
					emit       = 1'b1;
					rsp_d.last = 1'b1;
					st_d       = BK_IDLE;
				end else begin
					row_d   = AW'(row_q + 1'b1);
					rd_addr = AW'(row_q + 1'b1);
					rd_ok   = 1'b1;
				end
			end
			BK_QRY: begin
				emit          = 1'b1;
				rsp_d.blocked = row_data[job_q.x[AW-1:0]];
				rsp_d.last    = 1'b1;
				st_d          = BK_IDLE;
			end
			BK_NB_MID: begin
				up_d    = col3(row_data, job_q.x);
				rd_addr = job_q.y[AW-1:0];
				rd_ok   = y7 < DIM_EXT;
				st_d    = BK_NB_DN;
			end
			BK_NB_DN: begin
				mid_d   = col3(row_data, job_q.x);
				rd_addr = yp1[AW-1:0];
				rd_ok   = yp1 < DIM_EXT;
				st_d    = BK_NB_EVAL;
			end
			BK_NB_EVAL: begin
				cand_d = cand_now;
				st_d   = BK_EMIT;
			end
			BK_EMIT: begin
				emit = 1'b1;
				if (cand_q == '0) begin
					rsp_d.last = 1'b1;
					st_d       = BK_IDLE;
				end else begin
					rsp_d.found      = 1'b1;
					rsp_d.neighbor_x = nx;
					rsp_d.neighbor_y = ny;
					rsp_d.last       = ((cand_q & ~sel) == '0);
					cand_d           = cand_q & ~sel;
					if ((cand_q & ~sel) == '0) begin
						st_d = BK_IDLE;
					end
				end
			end
			default: begin
				st_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= BK_IDLE;
			row_vld_q   <= '0;
			rsp_valid_q <= 1'b0;
			rd_ok_q     <= 1'b0;
		end else begin
			st_q        <= st_d;
			rsp_valid_q <= emit;
			rd_ok_q     <= rd_ok;
			if (we) begin
				row_vld_q[row_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		job_q     <= job_d;
		row_q     <= row_d;
		mask_q    <= mask_d;
		up_q      <= up_d;
		mid_q     <= mid_d;
		cand_q    <= cand_d;
		rd_addr_q <= rd_addr;
		rsp_q     <= rsp_d;
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/grid_obstacle_neighbor_engine_top.sv
// Obstruction map over a GRID_DIM x GRID_DIM grid with neighbour listing.
//
// Request channel: an item (cmd) is taken at a rising edge with start high
// and busy low. A two-entry queue sits behind the request side, so busy only
// rises when two items wait for the executing part.
// Result channel: each result sits on rsp for exactly one cycle, flagged by
// rsp_valid, and the receiver cannot hold it off. rsp.last closes each item.
// Configuration channel: cfg_valid / cfg_ready (always ready), cfg_index
// selects width, height or diagonal mode; write only while the block is idle.
//
// Steps per item once it reaches the head of the queue, set by the row
// memory (one read port and one write port, one row each per cycle):
//   mark, clear, query      row read, then row write or registered result
//   fill rectangle          row reads and writes, one row per cycle
//   error and unused codes  result without a row read
//   list neighbours         three row reads, one select, then
//                           one result per cycle
// Reset clears the per-row valid bits, so the whole map reads as clear at
// once: no clearing pass. Size registers reset to 64, diagonal mode to off.
module grid_obstacle_neighbor_engine_top import gone_pkg::*; #(
	parameter int GRID_DIM = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  cmd_t                 cmd,
	output logic                 busy,
	output rsp_t                 rsp,
	output logic                 rsp_valid,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t cfg_q;
	job_t head;
	logic head_vld;
	logic pop;

	// configuration registers; unknown indexes are dropped
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width     <= SIZE_RST;
			cfg_q.grid_height    <= SIZE_RST;
			cfg_q.diagonal_moves <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_WIDTH:  cfg_q.grid_width     <= cfg_data;
				REG_HEIGHT: cfg_q.grid_height    <= cfg_data;
				REG_DIAG:   cfg_q.diagonal_moves <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// request side: take and classify items, hold them in the queue
	gone_front #(
		.GRID_DIM(GRID_DIM)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.busy     (busy),
		.head     (head),
		.head_vld (head_vld),
		.pop      (pop)
	);

	// executing side: row memory, edits, queries and neighbour walk
	gone_back #(
		.GRID_DIM(GRID_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (head),
		.head_vld  (head_vld),
		.pop       (pop),
		.rsp       (rsp),
		.rsp_valid (rsp_valid)
	);

	// a listed neighbour always lies inside the stored map
	a_nb_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.found |->
			({1'b0, rsp.neighbor_x} < (COORD_W + 1)'(GRID_DIM)) &&
			({1'b0, rsp.neighbor_y} < (COORD_W + 1)'(GRID_DIM)))
		else $error("neighbour outside map");

	// a rejected rectangle gives a single plain error result
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status |-> !rsp.found && !rsp.blocked && rsp.last)
		else $error("error result carries other fields");

	// only neighbour results can be followed by more of the same item
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.last)
		else $error("non-neighbour result without last");

	// results of one item come back to back
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.last |=> rsp_valid)
		else $error("gap inside a result burst");

endmodule
